### hw/rtl/kogc_pkg.sv
// ----------------------------------------------------------------------------
// kogc_pkg: shared types and constants of the key-ordered greedy colourer
// Item layouts of both channels, mode codes and the control bundle that
// joins the sequencer to the datapath.
// ----------------------------------------------------------------------------
package kogc_pkg;

  localparam int ROW_BITS = 32;
  localparam int SUM_BITS = 22;
  localparam int OUT_COST_BITS = 21;
  localparam int CFG_BITS = 6;
  localparam logic [CFG_BITS-1:0] VCOUNT_RESET = 6'd32;
  localparam logic [SUM_BITS-1:0] SUM_MAX = 22'h3FFFFF;
  localparam logic [OUT_COST_BITS-1:0] OUT_COST_MAX = 21'h1FFFFF;

  typedef enum logic [1:0] {
    MODE_LOAD_VERTEX = 2'd0,
    MODE_LOAD_COST   = 2'd1,
    MODE_RUN         = 2'd2,
    MODE_UNUSED      = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  slot_index;
    logic [15:0] vertex_key;
    logic [31:0] adjacency_row;
    logic [15:0] color_cost;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  vertex_id;
    logic [4:0]  assigned_color;
    logic [20:0] total_cost;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic vtx_clr;
    logic vtx_inc;
    logic sweep_start;
    logic sweep;
    logic color_phase;
    logic key_fetch;
    logic key_latch;
    logic visit_wr;
    logic visit_rd;
    logic adj_rd;
    logic pick;
    logic color_wr;
    logic sum_add;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic idx_last;
    logic vtx_last;
    logic out_free;
  } stat_t;

endpackage

### hw/rtl/kogc_datapath.sv
// ----------------------------------------------------------------------------
// kogc_datapath: tables, counters and arithmetic of the colourer
// Holds the key, adjacency, cost, visit-order and colour memories, the
// rank and used-colour accumulators, the cost sum and the output register.
// ----------------------------------------------------------------------------
module kogc_datapath #(
  parameter int MAX_VERTICES = 32,
  parameter int KEY_BITS     = 16,
  parameter int COST_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  kogc_pkg::cmd_t      cmd,
  output kogc_pkg::stat_t     stat,
  input  logic                in_accept,
  input  kogc_pkg::in_item_t  in_data,
  input  logic                cfg_wr_en,
  input  logic [5:0]          cfg_wr_data,
  input  logic                out_stall,
  output logic                out_valid,
  output kogc_pkg::out_item_t out_data
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int ADD_W = ((COST_BITS > kogc_pkg::SUM_BITS) ? COST_BITS
                                                           : kogc_pkg::SUM_BITS) + 1;

  logic [KEY_BITS-1:0]     key_mem   [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_mem   [MAX_VERTICES];
  logic [COST_BITS-1:0]    cost_mem  [MAX_VERTICES];
  logic [VW-1:0]           visit_mem [MAX_VERTICES];
  logic [VW-1:0]           col_mem   [MAX_VERTICES];

  logic [5:0]                   vertex_count;
  logic [CW-1:0]                n_eff;
  logic [CW-1:0]                n_run;
  logic [CW-1:0]                n_last;
  logic [VW-1:0]                vtx;
  logic [VW-1:0]                idx;
  logic                         pend;
  logic [VW-1:0]                pend_idx;
  logic [KEY_BITS-1:0]          key_q;
  logic [KEY_BITS-1:0]          key_v;
  logic [MAX_VERTICES-1:0]      adj_q;
  logic [COST_BITS-1:0]         cost_q;
  logic [VW-1:0]                visit_q;
  logic [VW-1:0]                col_q;
  logic [VW-1:0]                rank;
  logic [VW-1:0]                cur;
  logic [MAX_VERTICES-1:0]      used;
  logic [MAX_VERTICES-1:0]      visited;
  logic [VW-1:0]                color;
  logic [VW-1:0]                free_color;
  logic [kogc_pkg::SUM_BITS-1:0] sum;
  logic [ADD_W-1:0]             sum_ext;
  logic [kogc_pkg::SUM_BITS-1:0] sum_next;
  logic                         slot_ok;
  logic                         key_rd_en;
  logic [VW-1:0]                key_addr;
  logic                         rank_hit;

  assign slot_ok = int'(in_data.slot_index) < MAX_VERTICES;
  assign n_eff = (int'(vertex_count) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                      : CW'(vertex_count);
  assign n_last = n_run - CW'(1);

  assign stat.n_zero   = (n_eff == '0);
  assign stat.idx_last = (CW'(idx) == n_last);
  assign stat.vtx_last = (CW'(vtx) == n_last);
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= kogc_pkg::VCOUNT_RESET;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  // Table loads.
  always_ff @(posedge clk) begin
    if (in_accept && slot_ok &&
        in_data.mode == kogc_pkg::MODE_LOAD_VERTEX) begin
      key_mem[VW'(in_data.slot_index)] <= KEY_BITS'(in_data.vertex_key);
      adj_mem[VW'(in_data.slot_index)] <= MAX_VERTICES'(in_data.adjacency_row);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && slot_ok && in_data.mode == kogc_pkg::MODE_LOAD_COST) begin
      cost_mem[VW'(in_data.slot_index)] <= COST_BITS'(in_data.color_cost);
    end
  end

  assign key_rd_en = cmd.key_fetch || (cmd.sweep && !cmd.color_phase);
  assign key_addr  = cmd.key_fetch ? vtx : idx;

  always_ff @(posedge clk) begin
    if (key_rd_en) begin
      key_q <= key_mem[key_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.adj_rd) begin
      adj_q <= adj_mem[visit_q];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.color_wr) begin
      cost_q <= cost_mem[color];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.visit_wr) begin
      visit_mem[rank] <= vtx;
    end
    if (cmd.visit_rd) begin
      visit_q <= visit_mem[vtx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.color_wr) begin
      col_mem[cur] <= color;
    end
    if (cmd.sweep && cmd.color_phase) begin
      col_q <= col_mem[idx];
    end
  end

  // Counters and run-wide registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vtx  <= '0;
      idx  <= '0;
      pend <= 1'b0;
    end else begin
      if (cmd.start || cmd.vtx_clr) begin
        vtx <= '0;
      end else if (cmd.vtx_inc) begin
        vtx <= vtx + VW'(1);
      end
      if (cmd.sweep_start) begin
        idx <= '0;
      end else if (cmd.sweep) begin
        idx <= idx + VW'(1);
      end
      pend <= cmd.sweep;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= idx;
    if (cmd.start) begin
      n_run <= n_eff;
    end
    if (cmd.key_latch) begin
      key_v <= key_q;
    end
    if (cmd.adj_rd) begin
      cur <= visit_q;
    end
    if (cmd.pick) begin
      color <= free_color;
    end
  end

  // A vertex ranks below the current one when its key is smaller, or equal
  // with a lower index.
  assign rank_hit = (key_q < key_v) || ((key_q == key_v) && (pend_idx < vtx));

  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      rank <= '0;
      used <= '0;
    end else if (pend) begin
      if (!cmd.color_phase && rank_hit) begin
        rank <= rank + VW'(1);
      end
      if (cmd.color_phase && visited[pend_idx] && adj_q[pend_idx]) begin
        used[col_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      visited <= '0;
    end else if (cmd.color_wr) begin
      visited[cur] <= 1'b1;
    end
  end

  always_comb begin
    free_color = '0;
    for (int c = MAX_VERTICES - 1; c >= 0; c--) begin
      if (!used[c]) begin
        free_color = VW'(c);
      end
    end
  end

  assign sum_ext  = ADD_W'(sum) + ADD_W'(cost_q);
  assign sum_next = (sum_ext > ADD_W'(kogc_pkg::SUM_MAX)) ? kogc_pkg::SUM_MAX
                                                          : sum_ext[kogc_pkg::SUM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      sum <= '0;
    end else if (cmd.sum_add) begin
      sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.vertex_id      <= 5'(cur);
      out_data.assigned_color <= 5'(color);
      out_data.total_cost     <= sum[kogc_pkg::SUM_BITS-1] ? kogc_pkg::OUT_COST_MAX
                                                           : sum[kogc_pkg::OUT_COST_BITS-1:0];
      out_data.last           <= stat.vtx_last;
    end
  end

endmodule

### hw/rtl/kogc_ctrl.sv
// ----------------------------------------------------------------------------
// kogc_ctrl: sequencer of the colourer
// Walks the ranking sweeps and then the colouring sweeps, one vertex at a
// time, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module kogc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_accept,
  input  logic [1:0]      in_mode,
  input  kogc_pkg::stat_t stat,
  output logic            in_stall,
  output kogc_pkg::cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_R_KEY   = 14'b00000000000010,
    S_R_LATCH = 14'b00000000000100,
    S_R_SWEEP = 14'b00000000001000,
    S_R_DRAIN = 14'b00000000010000,
    S_R_WRITE = 14'b00000000100000,
    S_C_VIS   = 14'b00000001000000,
    S_C_ADJ   = 14'b00000010000000,
    S_C_SWEEP = 14'b00000100000000,
    S_C_DRAIN = 14'b00001000000000,
    S_C_PICK  = 14'b00010000000000,
    S_C_WRITE = 14'b00100000000000,
    S_C_SUM   = 14'b01000000000000,
    S_C_OUT   = 14'b10000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_accept && in_mode == kogc_pkg::MODE_RUN && !stat.n_zero) begin
          cmd.start  = 1'b1;
          state_next = S_R_KEY;
        end
      end
      S_R_KEY: begin
        cmd.key_fetch   = 1'b1;
        cmd.sweep_start = 1'b1;
        state_next      = S_R_LATCH;
      end
      S_R_LATCH: begin
        cmd.key_latch = 1'b1;
        state_next    = S_R_SWEEP;
      end
      S_R_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.idx_last) begin
          state_next = S_R_DRAIN;
        end
      end
      S_R_DRAIN: begin
        state_next = S_R_WRITE;
      end
      S_R_WRITE: begin
        cmd.visit_wr = 1'b1;
        if (stat.vtx_last) begin
          cmd.vtx_clr = 1'b1;
          state_next  = S_C_VIS;
        end else begin
          cmd.vtx_inc = 1'b1;
          state_next  = S_R_KEY;
        end
      end
      S_C_VIS: begin
        cmd.color_phase = 1'b1;
        cmd.visit_rd    = 1'b1;
        cmd.sweep_start = 1'b1;
        state_next      = S_C_ADJ;
      end
      S_C_ADJ: begin
        cmd.color_phase = 1'b1;
        cmd.adj_rd      = 1'b1;
        state_next      = S_C_SWEEP;
      end
      S_C_SWEEP: begin
        cmd.color_phase = 1'b1;
        cmd.sweep       = 1'b1;
        if (stat.idx_last) begin
          state_next = S_C_DRAIN;
        end
      end
      S_C_DRAIN: begin
        cmd.color_phase = 1'b1;
        state_next      = S_C_PICK;
      end
      S_C_PICK: begin
        cmd.color_phase = 1'b1;
        cmd.pick        = 1'b1;
        state_next      = S_C_WRITE;
      end
      S_C_WRITE: begin
        cmd.color_phase = 1'b1;
        cmd.color_wr    = 1'b1;
        state_next      = S_C_SUM;
      end
      S_C_SUM: begin
        cmd.color_phase = 1'b1;
        cmd.sum_add     = 1'b1;
        state_next      = S_C_OUT;
      end
      S_C_OUT: begin
        cmd.color_phase = 1'b1;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.vtx_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.vtx_inc = 1'b1;
            state_next  = S_C_VIS;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/key_ordered_greedy_coloring_top.sv
// ----------------------------------------------------------------------------
// key_ordered_greedy_coloring_top: random-key greedy graph colourer
// Loads vertex keys, adjacency rows and colour costs, then colours the
// vertices in ascending key order and streams one result per vertex.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid, in_stall, in_data) carries three kinds
// of item. A vertex load writes a key and an adjacency row, a cost load
// writes one colour cost; neither produces a result.
// A run item starts the colouring of the first vertex_count vertices (set
// through cfg_wr_en and cfg_wr_data while the block is idle; it resets to
// 32 and saturates at MAX_VERTICES). A run with a count of zero does nothing.
// During a run the block stalls the input. It first ranks every vertex by
// a sweep over the key memory and then colours each vertex by a sweep
// over the colour memory; each table memory has a single read port. The
// last result carries the last flag. Results sit in an output register;
// while the receiver stalls, the sequencer waits before loading the next
// result. Reset clears the sequencer, the output valid and the cost sum
// and sets vertex_count to 32; the tables hold nothing defined until
// loaded.
// ----------------------------------------------------------------------------
module key_ordered_greedy_coloring_top #(
  parameter int MAX_VERTICES = 32,
  parameter int KEY_BITS     = 16,
  parameter int COST_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [5:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  kogc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output kogc_pkg::out_item_t out_data
);

  kogc_pkg::cmd_t  cmd;
  kogc_pkg::stat_t stat;
  logic            in_accept;

  // An item is taken only while the sequencer is idle.
  assign in_accept = in_valid && !in_stall;

  kogc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_mode   (in_data.mode),
    .stat      (stat),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  kogc_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .KEY_BITS     (KEY_BITS),
    .COST_BITS    (COST_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_accept   (in_accept),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

### hw/rtl/kogc_checker.sv
// ----------------------------------------------------------------------------
// kogc_checker: port-level checks of the colourer
// Watches the channels of the top level and flags ordering slips.
// ----------------------------------------------------------------------------
module kogc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input kogc_pkg::out_item_t out_data
);

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A result that is not the last belongs to a run still in progress.
  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> in_stall)
    else $error("input open in mid run");

  // Once a result other than the last is taken, either the run goes on or
  // the next result is already waiting.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last |=> in_stall || out_valid)
    else $error("run ended without a last result");

endmodule

bind key_ordered_greedy_coloring_top kogc_checker u_kogc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
